FILE: rtl/urds_pkg.sv
// Shared types and codes for the undo/redo dual stack.
package urds_pkg;

    typedef enum logic [3:0] {
        REQ_OPEN_UNDO   = 4'd0,
        REQ_CLOSE_UNDO  = 4'd1,
        REQ_OPEN_REDO   = 4'd2,
        REQ_CLOSE_REDO  = 4'd3,
        REQ_PUSH        = 4'd4,
        REQ_BEGIN_UNDO  = 4'd5,
        REQ_FINISH_UNDO = 4'd6,
        REQ_RESTORE     = 4'd7,
        REQ_SKIP_UNDO   = 4'd8,
        REQ_BEGIN_REDO  = 4'd9,
        REQ_FINISH_REDO = 4'd10,
        REQ_POP         = 4'd11,
        REQ_CLEAR_REDO  = 4'd12
    } t_req;

    typedef enum logic [2:0] {
        M_INACTIVE  = 3'd0,
        M_UNDO_PUSH = 3'd1,
        M_REDO_PUSH = 3'd2,
        M_UNDO_POP  = 3'd3,
        M_REDO_POP  = 3'd4
    } t_mode;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FALSE = 2'd1;
    localparam logic [1:0] ST_DENY = 2'd2;

    localparam int CFG_W = 13;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [31:0] push_word;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_word;
        logic [12:0] record_left;
    } t_out_beat;

    // memory access from the control sequencer
    typedef struct packed {
        logic        we;
        logic [31:0] wdata;
    } t_mem_cmd;

endpackage

FILE: rtl/undo_redo_dual_stack.sv
// Undo/redo dual stack: one word store, control sequencer and eviction walker.
//
// Usage: drive i_req with a request and pulse start while busy is low. The
// block raises busy, works through the request, and shows the result on
// o_rsp for exactly one cycle with o_done high; busy falls with that cycle.
// The receiver cannot stall, so every result is taken in the cycle shown.
// A new request can be accepted at the edge that ends the result cycle.
// Simple requests pass through address, memory read, update and respond
// steps; a pop also waits for the popped word to be read, and a push or
// close that fits first checks for room. Pushes and closes that must make
// room walk record headers one memory read at a time and move every
// surviving word with one read and one write. All cost sits on the single
// memory port of the word store.
// Configuration: i_cfg_we with i_cfg_data sets the active store size
// (saturated to 2..STORE_WORDS) and empties both stacks; write it only while
// idle. Reset (i_rst_n low, synchronous) empties both stacks and sets the
// size to 4096 saturated. Store contents are not cleared; the stack pointers
// never expose an unwritten word under legal use.
module undo_redo_dual_stack #(
    parameter int STORE_WORDS = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  urds_pkg::t_in_beat  i_req,
    output logic                o_done,
    output urds_pkg::t_out_beat o_rsp,
    input  logic                i_cfg_we,
    input  logic [12:0]         i_cfg_data
);
    localparam int AW = $clog2(STORE_WORDS);
    localparam int PW = AW + 1;
    localparam logic [PW-1:0] SMAX = PW'(STORE_WORDS);

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_WAIT, S_EXEC,
        S_MR_START, S_UW_RD, S_UW_WT, S_UW_CHK, S_UMV_RD, S_UMV_WT,
        S_UMV_WR, S_R_START, S_RW_RD, S_RW_WT, S_RW_CHK, S_RMV_RD,
        S_RMV_WT, S_RMV_WR, S_MR_DONE, S_FINAL, S_POP_WT
    } t_state;

    t_state                r_state;
    urds_pkg::t_in_beat    r_req;
    logic [PW-1:0]         r_bw, r_ut, r_ust, r_rb, r_rw;
    urds_pkg::t_mode       r_mode;
    logic                  r_ovf;
    logic [PW-1:0]         r_need, r_clear, r_idx, r_i, r_es;
    logic                  r_room;
    logic [1:0]            r_st;
    logic [31:0]           r_rdw;

    logic                  r_we;
    logic [AW-1:0]         r_addr;
    logic [31:0]           r_wdata, w_rdata;

    urds_mem #(.AW(AW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (r_we),
        .i_addr (r_addr),
        .i_wdata(r_wdata),
        .o_rdata(w_rdata)
    );

    function automatic logic [PW-1:0] clamp(input logic [12:0] v);
        logic [16:0] w;
        w = 17'(v);
        if (w < 17'd2) return PW'(2);
        if (w > 17'(STORE_WORDS)) return SMAX;
        return PW'(w);
    endfunction

    // header value saturated to pointer width
    logic [PW-1:0] w_blk;
    always_comb begin
        if (|(w_rdata >> PW)) w_blk = '1;
        else w_blk = PW'(w_rdata);
    end
    logic w_big;
    assign w_big = |(w_rdata >> PW);

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        r_we   <= 1'b0;
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bw    <= clamp(13'd4096);
            r_ut    <= '0;
            r_ust   <= '0;
            r_rb    <= clamp(13'd4096);
            r_rw    <= '0;
            r_mode  <= urds_pkg::M_INACTIVE;
            r_ovf   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_we) begin
                        r_bw   <= clamp(i_cfg_data);
                        r_rb   <= clamp(i_cfg_data);
                        r_ut   <= '0;
                        r_ust  <= '0;
                        r_rw   <= '0;
                        r_mode <= urds_pkg::M_INACTIVE;
                        r_ovf  <= 1'b0;
                    end else if (start) begin
                        r_req   <= i_req;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    // address for the header read that some requests need
                    case (r_req.req_type)
                        urds_pkg::REQ_BEGIN_UNDO: r_addr <= AW'(r_ut - 1'b1);
                        urds_pkg::REQ_SKIP_UNDO:  r_addr <= AW'(r_ut - 1'b1);
                        urds_pkg::REQ_BEGIN_REDO: r_addr <= AW'(r_rb);
                        default:                  r_addr <= AW'(r_ut - 1'b1);
                    endcase
                    r_state <= S_WAIT;
                end
                S_WAIT: r_state <= S_EXEC;
                S_EXEC: begin
                    r_st    <= urds_pkg::ST_DENY;
                    r_rdw   <= '0;
                    r_state <= S_FINAL;
                    case (r_req.req_type)
                        urds_pkg::REQ_OPEN_UNDO, urds_pkg::REQ_OPEN_REDO: begin
                            if (r_mode == urds_pkg::M_INACTIVE) begin
                                r_mode <= (r_req.req_type == urds_pkg::REQ_OPEN_UNDO)
                                        ? urds_pkg::M_UNDO_PUSH : urds_pkg::M_REDO_PUSH;
                                r_rw  <= '0;
                                r_ovf <= 1'b0;
                                r_st  <= urds_pkg::ST_OK;
                            end
                        end
                        urds_pkg::REQ_CLOSE_UNDO, urds_pkg::REQ_CLOSE_REDO: begin
                            if (r_mode == ((r_req.req_type == urds_pkg::REQ_CLOSE_UNDO)
                                    ? urds_pkg::M_UNDO_PUSH : urds_pkg::M_REDO_PUSH)) begin
                                if (r_ovf) begin
                                    r_room  <= 1'b0;
                                    r_state <= S_MR_DONE;
                                end else begin
                                    r_need  <= PW'(1);
                                    r_state <= S_MR_START;
                                end
                            end
                        end
                        urds_pkg::REQ_PUSH: begin
                            if (r_mode == urds_pkg::M_UNDO_PUSH ||
                                r_mode == urds_pkg::M_REDO_PUSH) begin
                                if (r_ovf) r_st <= urds_pkg::ST_FALSE;
                                else begin
                                    r_need  <= PW'(2);
                                    r_state <= S_MR_START;
                                end
                            end
                        end
                        urds_pkg::REQ_BEGIN_UNDO: begin
                            if (r_mode == urds_pkg::M_INACTIVE) begin
                                if (r_ut == '0) r_st <= urds_pkg::ST_FALSE;
                                else begin
                                    r_ut   <= r_ut - 1'b1;
                                    r_rw   <= (w_blk > r_ut - 1'b1) ? r_ut - 1'b1 : w_blk;
                                    r_mode <= urds_pkg::M_UNDO_POP;
                                    r_st   <= urds_pkg::ST_OK;
                                end
                            end
                        end
                        urds_pkg::REQ_FINISH_UNDO, urds_pkg::REQ_RESTORE: begin
                            if (r_mode == urds_pkg::M_UNDO_POP && r_rw == '0) begin
                                if (r_req.req_type == urds_pkg::REQ_FINISH_UNDO) r_ust <= r_ut;
                                else r_ut <= r_ust;
                                r_mode <= urds_pkg::M_INACTIVE;
                                r_st   <= urds_pkg::ST_OK;
                            end
                        end
                        urds_pkg::REQ_SKIP_UNDO: begin
                            if (r_mode == urds_pkg::M_INACTIVE) begin
                                if (r_ut == '0) r_st <= urds_pkg::ST_FALSE;
                                else begin
                                    if (w_big || w_blk >= r_ut) begin
                                        r_ut <= '0; r_ust <= '0;
                                    end else begin
                                        r_ut  <= r_ut - 1'b1 - w_blk;
                                        r_ust <= r_ut - 1'b1 - w_blk;
                                    end
                                    r_st <= urds_pkg::ST_OK;
                                end
                            end
                        end
                        urds_pkg::REQ_BEGIN_REDO: begin
                            if (r_mode == urds_pkg::M_INACTIVE) begin
                                if (r_rb >= r_bw) r_st <= urds_pkg::ST_FALSE;
                                else begin
                                    r_rb   <= r_rb + 1'b1;
                                    r_rw   <= (w_blk > r_bw - r_rb - 1'b1)
                                            ? r_bw - r_rb - 1'b1 : w_blk;
                                    r_mode <= urds_pkg::M_REDO_POP;
                                    r_st   <= urds_pkg::ST_OK;
                                end
                            end
                        end
                        urds_pkg::REQ_FINISH_REDO: begin
                            if (r_mode == urds_pkg::M_REDO_POP && r_rw == '0) begin
                                r_mode <= urds_pkg::M_INACTIVE;
                                r_st   <= urds_pkg::ST_OK;
                            end
                        end
                        urds_pkg::REQ_POP: begin
                            if ((r_mode == urds_pkg::M_UNDO_POP ||
                                 r_mode == urds_pkg::M_REDO_POP) && r_rw != '0) begin
                                if (r_mode == urds_pkg::M_UNDO_POP) begin
                                    r_ut   <= r_ut - 1'b1;
                                    r_addr <= AW'(r_ut - 1'b1);
                                end else begin
                                    r_rb   <= r_rb + 1'b1;
                                    r_addr <= AW'(r_rb);
                                end
                                r_rw    <= r_rw - 1'b1;
                                r_st    <= urds_pkg::ST_OK;
                                r_i     <= '0;
                                r_state <= S_POP_WT;
                            end
                        end
                        urds_pkg::REQ_CLEAR_REDO: begin
                            if (r_mode != urds_pkg::M_REDO_PUSH &&
                                r_mode != urds_pkg::M_REDO_POP) begin
                                r_rb <= r_bw;
                                r_st <= urds_pkg::ST_OK;
                            end
                        end
                        default: ;
                    endcase
                end
                S_POP_WT: begin
                    // wait for the registered read to land
                    if (r_i == '0) r_i <= PW'(1);
                    else begin
                        r_rdw   <= w_rdata;
                        r_state <= S_FINAL;
                    end
                end
                S_MR_START: begin
                    if (r_need <= r_rb - r_ut) begin
                        r_room  <= 1'b1;
                        r_state <= S_MR_DONE;
                    end else begin
                        r_clear <= r_need - (r_rb - r_ut);
                        if (r_mode == urds_pkg::M_UNDO_PUSH)
                            r_idx <= (r_rw <= r_ut) ? r_ut - r_rw : '0;
                        else
                            r_idx <= r_ut;
                        r_state <= S_UW_RD;
                    end
                end
                S_UW_RD: begin
                    if (r_idx > r_clear) begin
                        r_addr  <= AW'(r_idx - 1'b1);
                        r_state <= S_UW_WT;
                    end else r_state <= S_UW_CHK;
                end
                S_UW_WT: r_state <= S_UW_CHK;
                S_UW_CHK: begin
                    if (r_idx > r_clear && !(w_big || w_blk >= r_idx) &&
                        !(r_idx - 1'b1 - w_blk < r_clear)) begin
                        r_idx   <= r_idx - 1'b1 - w_blk;
                        r_state <= S_UW_RD;
                    end else begin
                        r_ut    <= r_ut - r_idx;
                        r_ust   <= r_ut - r_idx;
                        r_i     <= '0;
                        r_state <= (r_idx != '0) ? S_UMV_RD : S_R_START;
                    end
                end
                S_UMV_RD: begin
                    if (r_i < r_ut) begin
                        r_addr  <= AW'(r_i + r_idx);
                        r_state <= S_UMV_WT;
                    end else r_state <= S_R_START;
                end
                S_UMV_WT: r_state <= S_UMV_WR;
                S_UMV_WR: begin
                    r_we    <= 1'b1;
                    r_addr  <= AW'(r_i);
                    r_wdata <= w_rdata;
                    r_i     <= r_i + 1'b1;
                    r_state <= S_UMV_RD;
                end
                S_R_START: begin
                    if (r_clear <= r_idx) begin
                        r_room  <= 1'b1;
                        r_state <= S_MR_DONE;
                    end else begin
                        r_clear <= r_clear - r_idx;
                        if (r_mode == urds_pkg::M_REDO_PUSH)
                            r_idx <= (r_rb + r_rw > r_bw) ? r_bw : r_rb + r_rw;
                        else
                            r_idx <= r_rb;
                        r_state <= S_RW_RD;
                    end
                end
                S_RW_RD: begin
                    if (r_idx < r_bw && r_bw - r_idx > r_clear) begin
                        r_addr  <= AW'(r_idx);
                        r_state <= S_RW_WT;
                    end else r_state <= S_RW_CHK;
                end
                S_RW_WT: r_state <= S_RW_CHK;
                S_RW_CHK: begin
                    if (r_idx < r_bw && r_bw - r_idx > r_clear &&
                        !(w_big || w_blk >= r_bw - r_idx) &&
                        !(r_bw - (r_idx + 1'b1 + w_blk) < r_clear)) begin
                        r_idx   <= r_idx + 1'b1 + w_blk;
                        r_state <= S_RW_RD;
                    end else begin
                        r_es    <= r_bw - r_idx;
                        r_i     <= r_idx;
                        r_state <= S_RMV_RD;
                    end
                end
                S_RMV_RD: begin
                    // move redo words up from the top end downward
                    if (r_es != '0 && r_i > r_rb) begin
                        r_addr  <= AW'(r_i - 1'b1);
                        r_state <= S_RMV_WT;
                    end else begin
                        r_rb    <= r_rb + r_es;
                        r_room  <= (r_clear <= r_es);
                        r_state <= S_MR_DONE;
                    end
                end
                S_RMV_WT: r_state <= S_RMV_WR;
                S_RMV_WR: begin
                    r_we    <= 1'b1;
                    r_addr  <= AW'(r_i - 1'b1 + r_es);
                    r_wdata <= w_rdata;
                    r_i     <= r_i - 1'b1;
                    r_state <= S_RMV_RD;
                end
                S_MR_DONE: begin
                    r_state <= S_FINAL;
                    if (r_req.req_type == urds_pkg::REQ_PUSH) begin
                        if (!r_room) begin
                            r_ovf <= 1'b1;
                            r_st  <= urds_pkg::ST_FALSE;
                        end else begin
                            r_we    <= 1'b1;
                            r_wdata <= r_req.push_word;
                            if (r_mode == urds_pkg::M_UNDO_PUSH) begin
                                r_addr <= AW'(r_ut);
                                r_ut   <= r_ut + 1'b1;
                            end else begin
                                r_addr <= AW'(r_rb - 1'b1);
                                r_rb   <= r_rb - 1'b1;
                            end
                            r_rw <= r_rw + 1'b1;
                            r_st <= urds_pkg::ST_OK;
                        end
                    end else begin
                        // close: commit header or discard the record
                        if (!r_room) begin
                            if (r_mode == urds_pkg::M_UNDO_PUSH) begin
                                r_ut  <= r_ut - r_rw;
                                r_ust <= r_ut - r_rw;
                            end else r_rb <= r_rb + r_rw;
                            r_st <= urds_pkg::ST_FALSE;
                        end else begin
                            r_we    <= 1'b1;
                            r_wdata <= 32'(r_rw);
                            if (r_mode == urds_pkg::M_UNDO_PUSH) begin
                                r_addr <= AW'(r_ut);
                                r_ut   <= r_ut + 1'b1;
                                r_ust  <= r_ut + 1'b1;
                            end else begin
                                r_addr <= AW'(r_rb - 1'b1);
                                r_rb   <= r_rb - 1'b1;
                            end
                            r_st <= urds_pkg::ST_OK;
                        end
                        r_rw   <= '0;
                        r_ovf  <= 1'b0;
                        r_mode <= urds_pkg::M_INACTIVE;
                    end
                end
                S_FINAL: begin
                    o_done            <= 1'b1;
                    o_rsp.status      <= r_st;
                    o_rsp.read_word   <= r_rdw;
                    o_rsp.record_left <= (r_mode == urds_pkg::M_INACTIVE) ? '0 : 13'(r_rw);
                    r_state           <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/urds_mem.sv
// Single-port word store with registered read data.
module urds_mem #(
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [31:0]   i_wdata,
    output logic [31:0]   o_rdata
);
    logic [31:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
